[rtl/core/mss_pkg.sv]
// shared types and constants for the servo sweep profile block
package mss_pkg;

    localparam int NUM_SERVOS = 32;
    localparam int PUSH_TIME  = 128;

    localparam int IDX_W    = 5;
    localparam int WIDTH_W  = 12;
    localparam int TIMER_W  = 9;
    localparam int ADDR_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int SPAN2_W  = WIDTH_W + 1;

    // step = floor(2*span / PUSH_TIME) as a multiply by a rounded-up reciprocal,
    // exact for a 13-bit numerator and a divisor below 256
    localparam int DIV_SHIFT = SPAN2_W + 8;
    localparam int RECIP_W   = DIV_SHIFT;
    localparam int PROD_W    = SPAN2_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SHIFT + PUSH_TIME - 1) / PUSH_TIME);

    localparam logic [TIMER_W-1:0] TIMER_LIMIT = TIMER_W'(2 * PUSH_TIME);
    localparam logic [TIMER_W-1:0] DRIVE_LIMIT = TIMER_W'(PUSH_TIME + PUSH_TIME / 2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = '1;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_REQUEST = 2'd1;
    localparam logic [1:0] FUNC_LOAD    = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [IDX_W-1:0]   servo_index;
        logic [WIDTH_W-1:0] rest_width;
        logic [WIDTH_W-1:0] strike_width;
    } item_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic [WIDTH_W-1:0] pulse_width;
        logic               moving_forward;
        logic               drive_enable;
        logic               last;
    } result_beat_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] rest;
        logic [WIDTH_W-1:0] strike;
        logic [WIDTH_W-1:0] cur;
        logic               fwd;
        logic               pend;
        logic [TIMER_W-1:0] timer;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_TICK
    } state_t;

endpackage

[rtl/core/mss_store.sv]
// servo entry memory with registered read and per-entry valid bits
module mss_store (
    input  logic             clk,
    input  logic             rst_n,
    input  mss_pkg::rd_req_t rd_req,
    input  mss_pkg::wr_req_t wr_req,
    output mss_pkg::entry_t  rd_data
);

    mss_pkg::entry_t               entry_ram [mss_pkg::NUM_SERVOS];
    mss_pkg::entry_t               rd_data_reg;
    logic [mss_pkg::NUM_SERVOS-1:0] vld_reg;
    logic                          rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            entry_ram[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= entry_ram[rd_req.addr];
        end
    end

    // never-written entries read as the all-zero reset entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                vld_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en)
            begin
                rd_vld_reg <= vld_reg[rd_req.addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/core/mss_advance.sv]
// one tick of sweep and timer update for a single servo entry
module mss_advance (
    input  mss_pkg::entry_t              entry_in,
    input  logic [mss_pkg::WIDTH_W-1:0]  step,
    output mss_pkg::entry_t              entry_out,
    output logic                         drive_enable
);

    always_comb
    begin
        logic                        fwd;
        logic [mss_pkg::TIMER_W-1:0] tmr;
        logic signed [mss_pkg::WIDTH_W+1:0] cur_s;
        logic signed [mss_pkg::WIDTH_W+1:0] up_s;
        logic signed [mss_pkg::WIDTH_W+1:0] dn_s;

        fwd   = entry_in.pend | entry_in.fwd;
        tmr   = entry_in.pend ? '0 : entry_in.timer;
        up_s  = $signed({2'b00, entry_in.cur}) + $signed({2'b00, step});
        dn_s  = $signed({2'b00, entry_in.cur}) - $signed({2'b00, step});
        cur_s = $signed({2'b00, entry_in.cur});

        if (entry_in.rest > entry_in.strike)
        begin
            if (fwd)
            begin
                if (entry_in.cur > entry_in.strike)
                begin
                    cur_s = dn_s;
                end
                else
                begin
                    fwd = 1'b0;
                end
            end
            else if (entry_in.cur < entry_in.rest)
            begin
                cur_s = up_s;
            end
        end
        else
        begin
            if (fwd)
            begin
                if (entry_in.cur < entry_in.strike)
                begin
                    cur_s = up_s;
                end
                else
                begin
                    fwd = 1'b0;
                end
            end
            else if (entry_in.cur > entry_in.rest)
            begin
                cur_s = dn_s;
            end
        end

        if (tmr < mss_pkg::TIMER_LIMIT)
        begin
            tmr = tmr + 1'b1;
        end

        entry_out        = entry_in;
        entry_out.fwd    = fwd;
        entry_out.pend   = 1'b0;
        entry_out.timer  = tmr;
        if (cur_s < 0)
        begin
            entry_out.cur = '0;
        end
        else if (cur_s > $signed({2'b00, mss_pkg::WIDTH_MAX}))
        begin
            entry_out.cur = mss_pkg::WIDTH_MAX;
        end
        else
        begin
            entry_out.cur = cur_s[mss_pkg::WIDTH_W-1:0];
        end
        drive_enable = tmr < mss_pkg::DRIVE_LIMIT;
    end

endmodule

[rtl/core/multi_servo_sweep_profile.sv]
// top level of the servo sweep profile block: sequencer, tick pipeline and store
//
// Items arrive on the item channel (valid/ready); func selects a millisecond
// tick, a note request or a load of one servo entry. Requests and loads give
// no result; each is a read-modify-write of the entry memory, read as the
// item is taken and written in ST_RMW, after which item_ready returns.
// A request or load with an index beyond the servo count, or an unused func
// code, is taken and does nothing. A tick walks all NUM_SERVOS entries in
// index order, one entry per cycle while result_ready does not stall, through
// the single read port of the entry memory: read, reciprocal multiply for the
// step, update and write back. It gives one result beat per servo on the
// result channel, with last set on the final one; each beat passes the memory
// read register, the s2 stage and the output register.
// A stall on result_ready freezes the whole tick pipeline; no beat is lost.
// item_ready stays low from a tick's acceptance until the cycle after its
// final beat enters the output register; the next item may be taken while
// that beat waits.
// Reset clears the per-entry valid bits at once, so every entry reads as
// all zero until it is written; no clearing pass is needed.
module multi_servo_sweep_profile (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  mss_pkg::item_beat_t   item_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output mss_pkg::result_beat_t result_data
);

    mss_pkg::state_t             state_reg;
    mss_pkg::state_t             state_next;
    mss_pkg::item_beat_t         hold_reg;
    mss_pkg::item_beat_t         hold_next;
    logic [mss_pkg::ADDR_W-1:0]  ctr_reg;
    logic [mss_pkg::ADDR_W-1:0]  ctr_next;
    logic                        issue_done_reg;
    logic                        issue_done_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [mss_pkg::ADDR_W-1:0]  s1_idx_reg;
    logic [mss_pkg::ADDR_W-1:0]  s1_idx_next;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic [mss_pkg::ADDR_W-1:0]  s2_idx_reg;
    logic [mss_pkg::ADDR_W-1:0]  s2_idx_next;
    mss_pkg::entry_t             s2_entry_reg;
    mss_pkg::entry_t             s2_entry_next;
    logic [mss_pkg::PROD_W-1:0]  s2_prod_reg;
    logic [mss_pkg::PROD_W-1:0]  s2_prod_next;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    mss_pkg::result_beat_t       result_reg;
    mss_pkg::result_beat_t       result_next;

    logic                        accept;
    logic                        in_range;
    logic                        rmw_start;
    logic                        adv;
    logic                        issue;
    logic [mss_pkg::WIDTH_W-1:0] span;
    mss_pkg::rd_req_t            rd_req;
    mss_pkg::wr_req_t            wr_req;
    mss_pkg::entry_t             store_data;
    mss_pkg::entry_t             adv_entry;
    logic                        adv_drive;

    assign accept   = item_valid && item_ready;
    assign in_range = {1'b0, item_data.servo_index} <
                      (mss_pkg::IDX_W + 1)'(mss_pkg::NUM_SERVOS);
    assign rmw_start = accept && in_range &&
                       (item_data.func == mss_pkg::FUNC_REQUEST ||
                        item_data.func == mss_pkg::FUNC_LOAD);
    // the whole tick pipeline moves only when the output register can take a beat
    assign adv = !result_valid_reg || result_ready;

    mss_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (store_data)
    );

    mss_advance u_advance (
        .entry_in     (s2_entry_reg),
        .step         (s2_prod_reg[mss_pkg::DIV_SHIFT +: mss_pkg::WIDTH_W]),
        .entry_out    (adv_entry),
        .drive_enable (adv_drive)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                if (accept && item_data.func == mss_pkg::FUNC_TICK)
                begin
                    state_next = mss_pkg::ST_TICK;
                end
                else if (rmw_start)
                begin
                    state_next = mss_pkg::ST_RMW;
                end
            end
            mss_pkg::ST_RMW:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
            mss_pkg::ST_TICK:
            begin
                if (issue_done_reg && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = mss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshake and memory ports
    always_comb
    begin
        item_ready  = 1'b0;
        issue       = 1'b0;
        rd_req.en   = 1'b0;
        rd_req.addr = item_data.servo_index[mss_pkg::ADDR_W-1:0];
        wr_req.en   = 1'b0;
        wr_req.addr = hold_reg.servo_index[mss_pkg::ADDR_W-1:0];
        wr_req.data = store_data;
        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                rd_req.en  = rmw_start;
            end
            mss_pkg::ST_RMW:
            begin
                wr_req.en = 1'b1;
                if (hold_reg.func == mss_pkg::FUNC_LOAD)
                begin
                    wr_req.data.rest   = hold_reg.rest_width;
                    wr_req.data.strike = hold_reg.strike_width;
                    wr_req.data.cur    = hold_reg.rest_width;
                end
                else
                begin
                    wr_req.data.pend = 1'b1;
                end
            end
            mss_pkg::ST_TICK:
            begin
                issue       = adv && !issue_done_reg;
                rd_req.en   = issue;
                rd_req.addr = ctr_reg;
                wr_req.en   = s2_valid_reg && adv;
                wr_req.addr = s2_idx_reg;
                wr_req.data = adv_entry;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // walk counter and pipeline stages
    always_comb
    begin
        ctr_next          = ctr_reg;
        issue_done_next   = issue_done_reg;
        hold_next         = accept ? item_data : hold_reg;
        s1_valid_next     = s1_valid_reg;
        s1_idx_next       = s1_idx_reg;
        s2_valid_next     = s2_valid_reg;
        s2_idx_next       = s2_idx_reg;
        s2_entry_next     = s2_entry_reg;
        s2_prod_next      = s2_prod_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        span = (store_data.rest > store_data.strike) ?
               store_data.rest - store_data.strike :
               store_data.strike - store_data.rest;

        if (accept && item_data.func == mss_pkg::FUNC_TICK)
        begin
            ctr_next        = '0;
            issue_done_next = 1'b0;
        end
        else if (issue)
        begin
            ctr_next        = ctr_reg + 1'b1;
            issue_done_next = ctr_reg == mss_pkg::ADDR_W'(mss_pkg::NUM_SERVOS - 1);
        end

        if (adv)
        begin
            s1_valid_next     = issue;
            s1_idx_next       = ctr_reg;
            s2_valid_next     = s1_valid_reg;
            s2_idx_next       = s1_idx_reg;
            s2_entry_next     = store_data;
            s2_prod_next      = mss_pkg::PROD_W'({span, 1'b0}) *
                                mss_pkg::PROD_W'(mss_pkg::RECIP);
            result_valid_next = s2_valid_reg;
            if (s2_valid_reg)
            begin
                result_next.out_index      = mss_pkg::IDX_W'(s2_idx_reg);
                result_next.pulse_width    = adv_entry.cur;
                result_next.moving_forward = adv_entry.fwd;
                result_next.drive_enable   = adv_drive;
                result_next.last           =
                    s2_idx_reg == mss_pkg::ADDR_W'(mss_pkg::NUM_SERVOS - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mss_pkg::ST_IDLE;
            issue_done_reg   <= 1'b1;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            ctr_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_done_reg   <= issue_done_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
            ctr_reg          <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        s2_entry_reg <= s2_entry_next;
        s2_prod_reg  <= s2_prod_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !s1_valid_reg && !s2_valid_reg)
        else $error("item taken while tick pipeline busy");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.last) |->
            result_data.out_index == mss_pkg::IDX_W'(mss_pkg::NUM_SERVOS - 1))
        else $error("last beat on wrong servo");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_req.en && rd_req.en) |-> wr_req.addr != rd_req.addr)
        else $error("read and write of one entry in the same cycle");

    a_tick_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mss_pkg::ST_TICK && state_next == mss_pkg::ST_IDLE) |->
            issue_done_reg && !s2_valid_reg)
        else $error("tick left before all entries written back");

endmodule
